FILE: design/diamond_angle_to_unit_vector_defines.svh
// Assertion macros shared by the diamond angle to unit vector design.
`ifndef DIAMOND_ANGLE_TO_UNIT_VECTOR_DEFINES_SVH
`define DIAMOND_ANGLE_TO_UNIT_VECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DAUTV_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked outside reset.
`define DAUTV_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: design/dautv_pkg.sv
// Constants and types shared by the diamond angle to unit vector design.
package dautv_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_BITS = 24;
	localparam int OUT_BITS   = FRAC_BITS + 2;
	localparam int D_BITS     = FRAC_BITS + 2;
	localparam int MAG_BITS   = FRAC_BITS + 1;
	localparam int SQ_BITS    = 2 * FRAC_BITS + 1;

	// Square root: radicand is len2 scaled to sit at or below 2^62.
	localparam int SQRT_SHIFT = 62 - 2 * FRAC_BITS;
	localparam int RAD_BITS   = 64;
	localparam int ROOT_BITS  = 32;
	localparam int SQRT_STEPS = RAD_BITS / 2;
	localparam int SREM_BITS  = ROOT_BITS + 3;

	// Division: numerator is mag * 2^31 plus half the root.
	localparam int NUM_SHIFT  = 31;
	localparam int NUM_BITS   = MAG_BITS + NUM_SHIFT;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int DREM_BITS  = ROOT_BITS + 1;

	localparam logic [D_BITS-1:0] ONE_D   = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic [D_BITS-1:0] TWO_D   = {2'b10, {FRAC_BITS{1'b0}}};
	localparam logic [D_BITS-1:0] THREE_D = {2'b11, {FRAC_BITS{1'b0}}};
	localparam logic [QUO_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [OUT_BITS-1:0] ONE_OUT     = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic signed [OUT_BITS-1:0] NEG_ONE_OUT = {2'b11, {FRAC_BITS{1'b0}}};

	// Signs and magnitudes of the piecewise linear direction.
	typedef struct packed {
		logic                xneg;
		logic                yneg;
		logic [MAG_BITS-1:0] xmag;
		logic [MAG_BITS-1:0] ymag;
	} side_t;

	typedef struct packed {
		logic                 xneg;
		logic                 yneg;
		logic [NUM_BITS-1:0]  numx;
		logic [NUM_BITS-1:0]  numy;
		logic [ROOT_BITS-1:0] root;
	} div_in_t;

	typedef struct packed {
		logic                xneg;
		logic                yneg;
		logic [QUO_BITS-1:0] qx;
		logic [QUO_BITS-1:0] qy;
	} div_out_t;

endpackage

FILE: design/dautv_if.sv
// Valid/ready channel interfaces for angle input and unit vector output.
interface dautv_in_if;
	logic                                          valid;
	logic                                          ready;
	logic signed [dautv_pkg::ANGLE_BITS-1:0]       diamond_angle;

	modport source (output valid, output diamond_angle, input ready);
	modport sink (input valid, input diamond_angle, output ready);
endinterface

interface dautv_out_if;
	logic                                          valid;
	logic                                          ready;
	logic signed [dautv_pkg::OUT_BITS-1:0]         unit_x;
	logic signed [dautv_pkg::OUT_BITS-1:0]         unit_y;

	modport source (output valid, output unit_x, output unit_y, input ready);
	modport sink (input valid, input unit_x, input unit_y, output ready);
endinterface

FILE: design/dautv_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`include "diamond_angle_to_unit_vector_defines.svh"

module dautv_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [dautv_pkg::RAD_BITS-1:0]      radicand,
	input  dautv_pkg::side_t                    in_side,
	output logic                                out_valid,
	output logic [dautv_pkg::ROOT_BITS-1:0]     root,
	output dautv_pkg::side_t                    out_side
);

	logic                                valid_s [1:dautv_pkg::SQRT_STEPS];
	logic [dautv_pkg::ROOT_BITS-1:0]     root_s  [1:dautv_pkg::SQRT_STEPS];
	dautv_pkg::side_t                    side_s  [1:dautv_pkg::SQRT_STEPS];
	logic [dautv_pkg::RAD_BITS-1:0]      rad_s   [1:dautv_pkg::SQRT_STEPS-1];
	logic [dautv_pkg::SREM_BITS-1:0]     rem_s   [1:dautv_pkg::SQRT_STEPS-1];

	for (genvar g = 0; g < dautv_pkg::SQRT_STEPS; g++) begin : g_step
		logic                            v_prev;
		logic [dautv_pkg::RAD_BITS-1:0]  rad_prev;
		logic [dautv_pkg::SREM_BITS-1:0] rem_prev;
		logic [dautv_pkg::ROOT_BITS-1:0] root_prev;
		dautv_pkg::side_t                side_prev;
		logic [dautv_pkg::SREM_BITS-1:0] rem_sh;
		logic [dautv_pkg::SREM_BITS-1:0] trial;
		logic [dautv_pkg::SREM_BITS-1:0] rem_new;
		logic                            ge;

		if (g == 0) begin : g_first
			assign v_prev    = in_valid;
			assign rad_prev  = radicand;
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign side_prev = in_side;
		end else begin : g_next
			assign v_prev    = valid_s[g];
			assign rad_prev  = rad_s[g];
			assign rem_prev  = rem_s[g];
			assign root_prev = root_s[g];
			assign side_prev = side_s[g];
		end

		// Bring down the next two radicand bits and try root*4+1.
		assign rem_sh  = {rem_prev[dautv_pkg::SREM_BITS-3:0],
			rad_prev[2*(dautv_pkg::SQRT_STEPS-1-g) +: 2]};
		assign trial   = {{(dautv_pkg::SREM_BITS-dautv_pkg::ROOT_BITS-2){1'b0}},
			root_prev, 2'b01};
		assign ge      = rem_sh >= trial;
		assign rem_new = ge ? (rem_sh - trial) : rem_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[g+1] <= {root_prev[dautv_pkg::ROOT_BITS-2:0], ge};
				side_s[g+1] <= side_prev;
			end
		end

		if (g < dautv_pkg::SQRT_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[g+1] <= rad_prev;
					rem_s[g+1] <= rem_new;
				end
			end
		end
	end

	assign out_valid = valid_s[dautv_pkg::SQRT_STEPS];
	assign root      = root_s[dautv_pkg::SQRT_STEPS];
	assign out_side  = side_s[dautv_pkg::SQRT_STEPS];

	// The scaled length never drops below 2^61, so the root stays at or above 2^30.
	`DAUTV_ASSERT_IMPLY(a_root_floor, clk, arst_n, out_valid, root[dautv_pkg::ROOT_BITS-1:dautv_pkg::ROOT_BITS-2] != 2'b00, "isqrt: root below 2^30")

endmodule

FILE: design/dautv_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
module dautv_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  dautv_pkg::div_in_t     in_op,
	output logic                   out_valid,
	output dautv_pkg::div_out_t    out_res
);

	logic                                valid_s [1:dautv_pkg::QUO_BITS];
	logic [1:0]                          sign_s  [1:dautv_pkg::QUO_BITS];
	logic [dautv_pkg::QUO_BITS-1:0]      qx_s    [1:dautv_pkg::QUO_BITS];
	logic [dautv_pkg::QUO_BITS-1:0]      qy_s    [1:dautv_pkg::QUO_BITS];
	logic [dautv_pkg::NUM_BITS-1:0]      numx_s  [1:dautv_pkg::QUO_BITS-1];
	logic [dautv_pkg::NUM_BITS-1:0]      numy_s  [1:dautv_pkg::QUO_BITS-1];
	logic [dautv_pkg::ROOT_BITS-1:0]     root_s  [1:dautv_pkg::QUO_BITS-1];
	logic [dautv_pkg::DREM_BITS-1:0]     remx_s  [1:dautv_pkg::QUO_BITS-1];
	logic [dautv_pkg::DREM_BITS-1:0]     remy_s  [1:dautv_pkg::QUO_BITS-1];

	for (genvar g = 0; g < dautv_pkg::QUO_BITS; g++) begin : g_step
		logic                            v_prev;
		logic [1:0]                      sign_prev;
		logic [dautv_pkg::QUO_BITS-1:0]  qx_prev;
		logic [dautv_pkg::QUO_BITS-1:0]  qy_prev;
		logic [dautv_pkg::NUM_BITS-1:0]  numx_prev;
		logic [dautv_pkg::NUM_BITS-1:0]  numy_prev;
		logic [dautv_pkg::ROOT_BITS-1:0] root_prev;
		logic [dautv_pkg::DREM_BITS-1:0] remx_prev;
		logic [dautv_pkg::DREM_BITS-1:0] remy_prev;
		logic [dautv_pkg::DREM_BITS-1:0] divisor;
		logic [dautv_pkg::DREM_BITS-1:0] remx_sh;
		logic [dautv_pkg::DREM_BITS-1:0] remy_sh;
		logic                            gex;
		logic                            gey;

		if (g == 0) begin : g_first
			// Upper numerator bits are already below the divisor.
			assign v_prev    = in_valid;
			assign sign_prev = {in_op.xneg, in_op.yneg};
			assign qx_prev   = '0;
			assign qy_prev   = '0;
			assign numx_prev = in_op.numx;
			assign numy_prev = in_op.numy;
			assign root_prev = in_op.root;
			assign remx_prev = {{(dautv_pkg::DREM_BITS-dautv_pkg::NUM_BITS+dautv_pkg::QUO_BITS)
				{1'b0}}, in_op.numx[dautv_pkg::NUM_BITS-1:dautv_pkg::QUO_BITS]};
			assign remy_prev = {{(dautv_pkg::DREM_BITS-dautv_pkg::NUM_BITS+dautv_pkg::QUO_BITS)
				{1'b0}}, in_op.numy[dautv_pkg::NUM_BITS-1:dautv_pkg::QUO_BITS]};
		end else begin : g_next
			assign v_prev    = valid_s[g];
			assign sign_prev = sign_s[g];
			assign qx_prev   = qx_s[g];
			assign qy_prev   = qy_s[g];
			assign numx_prev = numx_s[g];
			assign numy_prev = numy_s[g];
			assign root_prev = root_s[g];
			assign remx_prev = remx_s[g];
			assign remy_prev = remy_s[g];
		end

		assign divisor = {1'b0, root_prev};
		assign remx_sh = {remx_prev[dautv_pkg::DREM_BITS-2:0],
			numx_prev[dautv_pkg::QUO_BITS-1-g]};
		assign remy_sh = {remy_prev[dautv_pkg::DREM_BITS-2:0],
			numy_prev[dautv_pkg::QUO_BITS-1-g]};
		assign gex     = remx_sh >= divisor;
		assign gey     = remy_sh >= divisor;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sign_s[g+1] <= sign_prev;
				qx_s[g+1]   <= {qx_prev[dautv_pkg::QUO_BITS-2:0], gex};
				qy_s[g+1]   <= {qy_prev[dautv_pkg::QUO_BITS-2:0], gey};
			end
		end

		if (g < dautv_pkg::QUO_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					numx_s[g+1] <= numx_prev;
					numy_s[g+1] <= numy_prev;
					root_s[g+1] <= root_prev;
					remx_s[g+1] <= gex ? (remx_sh - divisor) : remx_sh;
					remy_s[g+1] <= gey ? (remy_sh - divisor) : remy_sh;
				end
			end
		end
	end

	assign out_valid    = valid_s[dautv_pkg::QUO_BITS];
	assign out_res.xneg = sign_s[dautv_pkg::QUO_BITS][1];
	assign out_res.yneg = sign_s[dautv_pkg::QUO_BITS][0];
	assign out_res.qx   = qx_s[dautv_pkg::QUO_BITS];
	assign out_res.qy   = qy_s[dautv_pkg::QUO_BITS];

endmodule

FILE: design/diamond_angle_to_unit_vector.sv
// Top level: diamond angle to rounded Q1.16 unit direction vector.
//
// Converts a Q8.16 diamond angle (a full turn is 4.0) into a unit vector
// (unit_x, unit_y) in Q1.16, each part rounded to nearest and capped at 1.0.
// The angle wraps modulo 4; only its low FRAC_BITS+2 bits matter. The block
// is a fixed pipeline with no state between items: one angle may transfer
// on every clock while the skid slot is empty. The pipeline is made of the
// front end (wrap and fold, squares, sum of squares), 32 square root stages
// that each resolve one root bit, one stage forming the rounded numerators,
// FRAC_BITS+1 divider stages that each resolve one quotient bit for both
// parts at once, the cap/sign stage and the output register. A stall on the
// output side holds the output register, parks at most one more result in a
// skid register and then freezes the whole pipeline; nothing is dropped or
// repeated, and the input side keeps transferring until the skid fills.
`include "diamond_angle_to_unit_vector_defines.svh"

module diamond_angle_to_unit_vector (
	input  logic               clk,
	input  logic               arst_n,
	dautv_in_if.sink           angle,
	dautv_out_if.source        vec
);

	// Pipeline advance: the whole pipe moves unless the skid slot is full.
	logic en;
	logic take;

	// Stage 1: wrapped angle folded into signs and magnitudes.
	logic                                 valid_s1;
	dautv_pkg::side_t                     side_s1;
	logic [dautv_pkg::D_BITS-1:0]         d;
	dautv_pkg::side_t                     side_w;

	// Stage 2: squares of both magnitudes.
	logic                                 valid_s2;
	dautv_pkg::side_t                     side_s2;
	logic [dautv_pkg::SQ_BITS-1:0]        xsq_s2;
	logic [dautv_pkg::SQ_BITS-1:0]        ysq_s2;
	logic [2*dautv_pkg::MAG_BITS-1:0]     xprod;
	logic [2*dautv_pkg::MAG_BITS-1:0]     yprod;

	// Stage 3: squared length.
	logic                                 valid_s3;
	dautv_pkg::side_t                     side_s3;
	logic [dautv_pkg::SQ_BITS-1:0]        len2_s3;
	logic [dautv_pkg::SQ_BITS:0]          len_sum;
	logic [dautv_pkg::RAD_BITS-1:0]       radicand;

	// Square root output.
	logic                                 root_valid;
	logic [dautv_pkg::ROOT_BITS-1:0]      root;
	dautv_pkg::side_t                     root_side;

	// Stage 4: rounded numerators for the divider.
	logic                                 valid_s4;
	dautv_pkg::div_in_t                   div_in_s4;

	// Divider output.
	logic                                 quo_valid;
	dautv_pkg::div_out_t                  quo;

	// Stage 5: capped and signed result.
	logic                                 valid_s5;
	logic [dautv_pkg::OUT_BITS-1:0]       fx_s5;
	logic [dautv_pkg::OUT_BITS-1:0]       fy_s5;
	logic [dautv_pkg::QUO_BITS-1:0]       magx;
	logic [dautv_pkg::QUO_BITS-1:0]       magy;
	logic [dautv_pkg::OUT_BITS-1:0]       extx;
	logic [dautv_pkg::OUT_BITS-1:0]       exty;

	// Output register and skid slot.
	logic                                 out_valid_q;
	logic [dautv_pkg::OUT_BITS-1:0]       out_x_q;
	logic [dautv_pkg::OUT_BITS-1:0]       out_y_q;
	logic                                 skid_valid_q;
	logic [dautv_pkg::OUT_BITS-1:0]       skid_x_q;
	logic [dautv_pkg::OUT_BITS-1:0]       skid_y_q;

	assign en          = !skid_valid_q;
	assign angle.ready = en;
	assign take        = out_valid_q && vec.ready;

	// ---- Stage 1: wrap modulo 4 and fold onto the diamond ----
	// Keeping the low FRAC_BITS+2 bits of the two's complement angle is the wrap.
	assign d = angle.diamond_angle[dautv_pkg::D_BITS-1:0];

	always_comb begin
		logic [dautv_pkg::D_BITS-1:0] xdiff;
		logic [dautv_pkg::D_BITS-1:0] ydiff;

		// x: falls from 1 to -1 over [0,2), rises back over [2,4).
		if (d < dautv_pkg::TWO_D) begin
			side_w.xneg = d > dautv_pkg::ONE_D;
			xdiff = side_w.xneg ? (d - dautv_pkg::ONE_D) : (dautv_pkg::ONE_D - d);
		end else begin
			side_w.xneg = d < dautv_pkg::THREE_D;
			xdiff = side_w.xneg ? (dautv_pkg::THREE_D - d) : (d - dautv_pkg::THREE_D);
		end

		// y: rises to 1 on [0,1], falls to -1 by 3, rises to 0 at 4.
		priority if (d >= dautv_pkg::THREE_D) begin
			side_w.yneg = 1'b1;
			ydiff = '0 - d;
		end else if (d > dautv_pkg::ONE_D) begin
			side_w.yneg = d > dautv_pkg::TWO_D;
			ydiff = side_w.yneg ? (d - dautv_pkg::TWO_D) : (dautv_pkg::TWO_D - d);
		end else begin
			side_w.yneg = 1'b0;
			ydiff = d;
		end

		// Both magnitudes are at most 1.0, so the top bit of the difference drops.
		side_w.xmag = xdiff[dautv_pkg::MAG_BITS-1:0];
		side_w.ymag = ydiff[dautv_pkg::MAG_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= angle.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= root_valid;
			valid_s5 <= quo_valid;
		end
	end

	// ---- Stage 2: squares ----
	assign xprod = {{dautv_pkg::MAG_BITS{1'b0}}, side_s1.xmag}
		* {{dautv_pkg::MAG_BITS{1'b0}}, side_s1.xmag};
	assign yprod = {{dautv_pkg::MAG_BITS{1'b0}}, side_s1.ymag}
		* {{dautv_pkg::MAG_BITS{1'b0}}, side_s1.ymag};

	// ---- Stage 3: squared length, at most 1.0 squared ----
	assign len_sum  = {1'b0, xsq_s2} + {1'b0, ysq_s2};
	assign radicand = {{(dautv_pkg::RAD_BITS-dautv_pkg::SQ_BITS){1'b0}}, len2_s3}
		<< dautv_pkg::SQRT_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_w;
			side_s2 <= side_s1;
			xsq_s2  <= xprod[dautv_pkg::SQ_BITS-1:0];
			ysq_s2  <= yprod[dautv_pkg::SQ_BITS-1:0];
			side_s3 <= side_s2;
			len2_s3 <= len_sum[dautv_pkg::SQ_BITS-1:0];
		end
	end

	dautv_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.radicand  (radicand),
		.in_side   (side_s3),
		.out_valid (root_valid),
		.root      (root),
		.out_side  (root_side)
	);

	// ---- Stage 4: numerator = mag * 2^31 + root/2, so the quotient rounds half up ----
	always_ff @(posedge clk) begin
		if (en) begin
			div_in_s4.xneg <= root_side.xneg;
			div_in_s4.yneg <= root_side.yneg;
			div_in_s4.root <= root;
			div_in_s4.numx <= {root_side.xmag, {dautv_pkg::NUM_SHIFT{1'b0}}}
				+ {{(dautv_pkg::NUM_BITS-dautv_pkg::ROOT_BITS+1){1'b0}},
				root[dautv_pkg::ROOT_BITS-1:1]};
			div_in_s4.numy <= {root_side.ymag, {dautv_pkg::NUM_SHIFT{1'b0}}}
				+ {{(dautv_pkg::NUM_BITS-dautv_pkg::ROOT_BITS+1){1'b0}},
				root[dautv_pkg::ROOT_BITS-1:1]};
		end
	end

	dautv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_op     (div_in_s4),
		.out_valid (quo_valid),
		.out_res   (quo)
	);

	// ---- Stage 5: cap overshoot at 1.0 and apply the sign ----
	assign magx = (quo.qx > dautv_pkg::ONE_Q) ? dautv_pkg::ONE_Q : quo.qx;
	assign magy = (quo.qy > dautv_pkg::ONE_Q) ? dautv_pkg::ONE_Q : quo.qy;
	assign extx = {1'b0, magx};
	assign exty = {1'b0, magy};

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s5 <= quo.xneg ? (~extx + 1'b1) : extx;
			fy_s5 <= quo.yneg ? (~exty + 1'b1) : exty;
		end
	end

	// ---- Output register with one-entry skid ----
	// While the pipe advances, the leaving item goes to the output register if it
	// is free or being taken; otherwise park it in the skid slot, which then
	// freezes the pipe until the output register drains it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (!out_valid_q || take) begin
				out_valid_q <= valid_s5;
			end else if (valid_s5) begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_valid_q || take) begin
				out_x_q <= fx_s5;
				out_y_q <= fy_s5;
			end else if (valid_s5) begin
				skid_x_q <= fx_s5;
				skid_y_q <= fy_s5;
			end
		end else if (take) begin
			out_x_q <= skid_x_q;
			out_y_q <= skid_y_q;
		end
	end

	assign vec.valid  = out_valid_q;
	assign vec.unit_x = out_x_q;
	assign vec.unit_y = out_y_q;

	// Each delivered part lies within [-1.0, 1.0].
	`DAUTV_ASSERT_IMPLY(a_x_range, clk, arst_n, vec.valid, (vec.unit_x <= dautv_pkg::ONE_OUT) && (vec.unit_x >= dautv_pkg::NEG_ONE_OUT), "unit_x outside [-1,1]")
	`DAUTV_ASSERT_IMPLY(a_y_range, clk, arst_n, vec.valid, (vec.unit_y <= dautv_pkg::ONE_OUT) && (vec.unit_y >= dautv_pkg::NEG_ONE_OUT), "unit_y outside [-1,1]")
	// A unit vector never has both parts zero.
	`DAUTV_ASSERT_IMPLY(a_nonzero, clk, arst_n, vec.valid, (vec.unit_x != '0) || (vec.unit_y != '0), "zero result vector")
	// A result leaving the pipe into a blocked output register is parked, not lost.
	`DAUTV_ASSERT_NEXT(a_skid_park, clk, arst_n, en && out_valid_q && !vec.ready && valid_s5, skid_valid_q && out_valid_q, "blocked result not parked")
	// The skid slot fills only when the output register is blocked.
	`DAUTV_ASSERT_IMPLY(a_skid_cause, clk, arst_n, $rose(skid_valid_q), $past(out_valid_q && !vec.ready), "skid filled without a stall")

endmodule
